// ===== design/all_pairs_path_center_finder_assert.svh =====
// ============================================================================
// all_pairs_path_center_finder_assert.svh
// Assertion macros used by the checker module of this block.
// ============================================================================
`ifndef ALL_PAIRS_PATH_CENTER_FINDER_ASSERT_SVH
`define ALL_PAIRS_PATH_CENTER_FINDER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define APC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("apc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define APC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("apc assertion failed");

`endif

// ===== design/apc_pkg.sv =====
// ============================================================================
// apc_pkg
// Types, constants and codes of the all pairs path center finder.
// ============================================================================
package apc_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VTX_W        = $clog2(MAX_VERTICES);
    localparam int NCNT_W       = VTX_W + 1;
    localparam int ADDR_W       = 2 * VTX_W;
    localparam int DEPTH        = MAX_VERTICES * MAX_VERTICES;
    localparam int DIST_W       = 31;
    localparam int HOP_W        = VTX_W + 1;
    localparam int WEIGHT_W     = 24;
    localparam int ACC_W        = DIST_W + VTX_W;
    localparam int BT_W         = 11;
    localparam int ENTRY_W      = HOP_W + DIST_W;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 7;

    localparam logic [DIST_W-1:0] DIST_INF = '1;
    localparam logic [HOP_W-1:0]  HOP_NONE = HOP_W'(MAX_VERTICES);
    localparam logic [BT_W-1:0]   BT_MAX   = '1;

    localparam logic [1:0] ACT_CLEAR   = 2'd0;
    localparam logic [1:0] ACT_EDGE    = 2'd1;
    localparam logic [1:0] ACT_COMPUTE = 2'd2;
    localparam logic [1:0] ACT_QUERY   = 2'd3;

    localparam logic [1:0] MODE_BETWEEN = 2'd3;
    localparam logic [1:0] MODE_MAX     = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_MODE  = CFG_IDX_W'(1);

    typedef struct packed {
        logic [1:0]          action;
        logic [VTX_W-1:0]    vertex_a;
        logic [VTX_W-1:0]    vertex_b;
        logic [WEIGHT_W-1:0] edge_weight;
    } t_in_item;

    typedef struct packed {
        logic                result_kind;
        logic [VTX_W-1:0]    chosen_vertex;
        logic [DIST_W-1:0]   path_distance;
        logic                hop_known;
    } t_out_item;

    typedef struct packed {
        logic [HOP_W-1:0]  hop;
        logic [DIST_W-1:0] len;
    } t_entry;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_EDGE, S_IK_RD, S_IK_CAP, S_J_RD, S_J_UPD,
        S_ROW_RD, S_ROW_ACC, S_ROW_END, S_BT_RD, S_BT_ACC, S_BT_END,
        S_CENTER, S_Q_RD, S_Q_HOP, S_Q_DIST, S_DONE
    } t_state;

    typedef enum logic [4:0] {
        DP_NOP, DP_LOAD, DP_CLR, DP_EDGE, DP_IK_RD, DP_IK_CAP, DP_J_RD, DP_J_UPD,
        DP_ROW_RD, DP_ROW_ACC, DP_ROW_END, DP_BT_RD, DP_BT_ACC, DP_BT_END,
        DP_CENTER, DP_Q_RD, DP_Q_HOP, DP_Q_DIST
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic edge_last;
        logic j_last;
        logic i_last;
        logic k_last;
    } t_dp_stat;

endpackage

// ===== design/apc_ram.sv =====
// ============================================================================
// apc_ram
// Generic memory with one write port and two registered read ports.
// ============================================================================
module apc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata0;
    logic [WIDTH-1:0] r_rdata1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata0 <= r_mem[i_raddr0];
        r_rdata1 <= r_mem[i_raddr1];
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

// ===== design/apc_ctrl.sv =====
// ============================================================================
// apc_ctrl
// Sequencer that steps the datapath through clear, edge, compute and query.
// ============================================================================
module apc_ctrl
    import apc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_action,
    input  logic       i_mode_bt,
    input  t_dp_stat   i_stat,
    input  logic       i_out_free,
    output t_dp_cmd    o_cmd,
    output logic       o_idle
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd.op       = DP_NOP;
        o_cmd.out_load = 1'b0;
        o_idle         = 1'b0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.op = DP_CLR;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_idle = 1'b1;
                if (i_start) begin
                    o_cmd.op = DP_LOAD;
                    unique case (i_action)
                        ACT_CLEAR:   n_state = S_CLR;
                        ACT_EDGE:    n_state = S_EDGE;
                        ACT_COMPUTE: n_state = S_IK_RD;
                        default:     n_state = S_Q_RD;
                    endcase
                end
            end
            S_EDGE: begin
                o_cmd.op = DP_EDGE;
                if (i_stat.edge_last) n_state = S_IDLE;
            end
            S_IK_RD: begin
                o_cmd.op = DP_IK_RD;
                n_state  = S_IK_CAP;
            end
            S_IK_CAP: begin
                o_cmd.op = DP_IK_CAP;
                n_state  = S_J_RD;
            end
            S_J_RD: begin
                o_cmd.op = DP_J_RD;
                n_state  = S_J_UPD;
            end
            S_J_UPD: begin
                o_cmd.op = DP_J_UPD;
                priority if (i_stat.j_last && i_stat.i_last && i_stat.k_last) begin
                    n_state = i_mode_bt ? S_BT_RD : S_ROW_RD;
                end else if (i_stat.j_last) begin
                    n_state = S_IK_RD;
                end else begin
                    n_state = S_J_RD;
                end
            end
            S_ROW_RD: begin
                o_cmd.op = DP_ROW_RD;
                n_state  = S_ROW_ACC;
            end
            S_ROW_ACC: begin
                o_cmd.op = DP_ROW_ACC;
                n_state  = i_stat.j_last ? S_ROW_END : S_ROW_RD;
            end
            S_ROW_END: begin
                o_cmd.op = DP_ROW_END;
                n_state  = i_stat.i_last ? S_CENTER : S_ROW_RD;
            end
            S_BT_RD: begin
                o_cmd.op = DP_BT_RD;
                n_state  = S_BT_ACC;
            end
            S_BT_ACC: begin
                o_cmd.op = DP_BT_ACC;
                n_state  = (i_stat.j_last && i_stat.i_last) ? S_BT_END : S_BT_RD;
            end
            S_BT_END: begin
                o_cmd.op = DP_BT_END;
                n_state  = i_stat.k_last ? S_CENTER : S_BT_RD;
            end
            S_CENTER: begin
                o_cmd.op = DP_CENTER;
                n_state  = S_DONE;
            end
            S_Q_RD: begin
                o_cmd.op = DP_Q_RD;
                n_state  = S_Q_HOP;
            end
            S_Q_HOP: begin
                o_cmd.op = DP_Q_HOP;
                n_state  = S_Q_DIST;
            end
            S_Q_DIST: begin
                o_cmd.op = DP_Q_DIST;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase
    end

endmodule

// ===== design/apc_dp.sv =====
// ============================================================================
// apc_dp
// Matrix memory, loop counters, relaxation, center search and query logic.
// ============================================================================
module apc_dp
    import apc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  t_in_item          i_item,
    input  logic [NCNT_W-1:0] i_vcount,
    input  logic [1:0]        i_mode,
    output t_dp_stat          o_stat,
    output t_out_item         o_result
);

    logic [ADDR_W-1:0]   r_clr;
    logic [ADDR_W-1:0]   n_clr;
    logic [1:0]          r_step;
    logic [1:0]          n_step;
    logic [VTX_W-1:0]    r_k;
    logic [VTX_W-1:0]    n_k;
    logic [VTX_W-1:0]    r_i;
    logic [VTX_W-1:0]    n_i;
    logic [VTX_W-1:0]    r_j;
    logic [VTX_W-1:0]    n_j;
    logic [VTX_W-1:0]    r_a;
    logic [VTX_W-1:0]    n_a;
    logic [VTX_W-1:0]    r_b;
    logic [VTX_W-1:0]    n_b;
    logic [WEIGHT_W-1:0] r_w;
    logic [WEIGHT_W-1:0] n_w;
    logic [DIST_W-1:0]   r_dik;
    logic [DIST_W-1:0]   n_dik;
    logic [HOP_W-1:0]    r_hik;
    logic [HOP_W-1:0]    n_hik;
    logic [ACC_W-1:0]    r_acc;
    logic [ACC_W-1:0]    n_acc;
    logic [ACC_W-1:0]    r_best_val;
    logic [ACC_W-1:0]    n_best_val;
    logic [VTX_W-1:0]    r_best;
    logic [VTX_W-1:0]    n_best;
    logic [BT_W-1:0]     r_cnt;
    logic [BT_W-1:0]     n_cnt;
    logic                r_qok;
    logic                n_qok;
    logic [VTX_W-1:0]    r_hq;
    logic [VTX_W-1:0]    n_hq;
    t_out_item           r_res;
    t_out_item           n_res;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    t_entry            wdata;
    logic [ADDR_W-1:0] raddr0;
    logic [ADDR_W-1:0] raddr1;
    t_entry            rd0;
    t_entry            rd1;

    logic [VTX_W-1:0]  nm1;
    logic              a_ok;
    logic              b_ok;
    logic [DIST_W:0]   sum;
    logic [DIST_W-1:0] cand;
    logic [ACC_W-1:0]  dext;
    logic [ACC_W-1:0]  cext;

    apc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (waddr),
        .i_wdata  (wdata),
        .i_raddr0 (raddr0),
        .i_raddr1 (raddr1),
        .o_rdata0 (rd0),
        .o_rdata1 (rd1)
    );

    assign nm1  = VTX_W'(i_vcount - NCNT_W'(1));
    assign a_ok = {1'b0, r_a} < i_vcount;
    assign b_ok = {1'b0, r_b} < i_vcount;
    assign sum  = {1'b0, r_dik} + {1'b0, rd0.len};
    assign cand = (sum >= {1'b0, DIST_INF}) ? DIST_INF : sum[DIST_W-1:0];
    assign dext = ACC_W'(rd0.len);
    assign cext = ACC_W'(r_cnt);

    assign o_stat.clr_last  = (r_clr == '1);
    assign o_stat.edge_last = (r_step == '1);
    assign o_stat.j_last    = (r_j == nm1);
    assign o_stat.i_last    = (r_i == nm1);
    assign o_stat.k_last    = (r_k == nm1);
    assign o_result         = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_step <= '0;
            r_k    <= '0;
            r_i    <= '0;
            r_j    <= '0;
        end else begin
            r_clr  <= n_clr;
            r_step <= n_step;
            r_k    <= n_k;
            r_i    <= n_i;
            r_j    <= n_j;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a        <= n_a;
        r_b        <= n_b;
        r_w        <= n_w;
        r_dik      <= n_dik;
        r_hik      <= n_hik;
        r_acc      <= n_acc;
        r_best_val <= n_best_val;
        r_best     <= n_best;
        r_cnt      <= n_cnt;
        r_qok      <= n_qok;
        r_hq       <= n_hq;
        r_res      <= n_res;
    end

    always_comb begin
        n_clr      = r_clr;
        n_step     = r_step;
        n_k        = r_k;
        n_i        = r_i;
        n_j        = r_j;
        n_a        = r_a;
        n_b        = r_b;
        n_w        = r_w;
        n_dik      = r_dik;
        n_hik      = r_hik;
        n_acc      = r_acc;
        n_best_val = r_best_val;
        n_best     = r_best;
        n_cnt      = r_cnt;
        n_qok      = r_qok;
        n_hq       = r_hq;
        n_res      = r_res;
        we         = 1'b0;
        waddr      = '0;
        wdata      = '{hop: HOP_NONE, len: DIST_INF};
        raddr0     = '0;
        raddr1     = '0;
        unique case (i_cmd.op)
            DP_NOP: ;
            DP_LOAD: begin
                n_a   = i_item.vertex_a;
                n_b   = i_item.vertex_b;
                n_w   = i_item.edge_weight;
                n_k   = '0;
                n_i   = '0;
                n_j   = '0;
                n_acc = '0;
                n_cnt = '0;
            end
            DP_CLR: begin
                we    = 1'b1;
                waddr = r_clr;
                n_clr = r_clr + ADDR_W'(1);
            end
            DP_EDGE: begin
                we     = a_ok && b_ok;
                n_step = r_step + 2'd1;
                unique case (r_step)
                    2'd0: begin
                        waddr = {r_a, r_a};
                        wdata = '{hop: {1'b0, r_a}, len: '0};
                    end
                    2'd1: begin
                        waddr = {r_b, r_b};
                        wdata = '{hop: {1'b0, r_b}, len: '0};
                    end
                    2'd2: begin
                        waddr = {r_a, r_b};
                        wdata = '{hop: {1'b0, r_b}, len: DIST_W'(r_w)};
                    end
                    default: begin
                        waddr = {r_b, r_a};
                        wdata = '{hop: {1'b0, r_a}, len: DIST_W'(r_w)};
                    end
                endcase
            end
            DP_IK_RD: raddr0 = {r_i, r_k};
            DP_IK_CAP: begin
                n_dik = rd0.len;
                n_hik = rd0.hop;
            end
            DP_J_RD: begin
                raddr0 = {r_k, r_j};
                raddr1 = {r_i, r_j};
            end
            DP_J_UPD: begin
                we    = cand < rd1.len;
                waddr = {r_i, r_j};
                wdata = '{hop: r_hik, len: cand};
                if (o_stat.j_last) begin
                    n_j = '0;
                    if (o_stat.i_last) begin
                        n_i = '0;
                        n_k = o_stat.k_last ? '0 : r_k + VTX_W'(1);
                    end else begin
                        n_i = r_i + VTX_W'(1);
                    end
                end else begin
                    n_j = r_j + VTX_W'(1);
                end
            end
            DP_ROW_RD: raddr0 = {r_i, r_j};
            DP_ROW_ACC: begin
                if (i_mode == MODE_MAX) begin
                    n_acc = (dext > r_acc) ? dext : r_acc;
                end else begin
                    n_acc = r_acc + dext;
                end
                n_j = o_stat.j_last ? '0 : r_j + VTX_W'(1);
            end
            DP_ROW_END: begin
                if (r_i == '0 || r_acc < r_best_val) begin
                    n_best_val = r_acc;
                    n_best     = r_i;
                end
                n_acc = '0;
                n_i   = o_stat.i_last ? '0 : r_i + VTX_W'(1);
            end
            DP_BT_RD: raddr0 = {r_i, r_j};
            DP_BT_ACC: begin
                if (r_i < r_j && !rd0.hop[VTX_W] && rd0.hop[VTX_W-1:0] == r_k &&
                    r_k != r_i && r_k != r_j && r_cnt != BT_MAX) begin
                    n_cnt = r_cnt + BT_W'(1);
                end
                if (o_stat.j_last) begin
                    n_j = '0;
                    n_i = o_stat.i_last ? '0 : r_i + VTX_W'(1);
                end else begin
                    n_j = r_j + VTX_W'(1);
                end
            end
            DP_BT_END: begin
                if (r_k == '0 || cext > r_best_val) begin
                    n_best_val = cext;
                    n_best     = r_k;
                end
                n_cnt = '0;
                n_k   = o_stat.k_last ? '0 : r_k + VTX_W'(1);
            end
            DP_CENTER: begin
                n_res = '{result_kind: 1'b0, chosen_vertex: r_best,
                          path_distance: '0, hop_known: 1'b0};
            end
            DP_Q_RD: raddr0 = {r_a, r_b};
            DP_Q_HOP: begin
                raddr0 = {r_a, rd0.hop[VTX_W-1:0]};
                n_qok  = a_ok && b_ok && !rd0.hop[VTX_W];
                n_hq   = rd0.hop[VTX_W-1:0];
            end
            DP_Q_DIST: begin
                if (r_qok) begin
                    n_res = '{result_kind: 1'b1, chosen_vertex: r_hq,
                              path_distance: rd0.len, hop_known: 1'b1};
                end else begin
                    n_res = '{result_kind: 1'b1, chosen_vertex: '0,
                              path_distance: DIST_INF, hop_known: 1'b0};
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== design/all_pairs_path_center_finder.sv =====
// ============================================================================
// all_pairs_path_center_finder
// Floyd-Warshall all pairs shortest path engine with graph center selection.
// ============================================================================
// Input is busy after a clear beat while the matrix memory is cleared, and
// after an add edge beat while its entries are written. A query reads the
// first hop of the pair, then the distance to that hop; a compute relaxes
// every entry, a read and an update each, then scores vertices by row or by
// betweenness count. After reset a clearing pass runs with input ready low;
// configuration writes are taken at any time.
module all_pairs_path_center_finder
    import apc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [NCNT_W-1:0] r_vcount;
    logic [1:0]        r_mode;
    logic [NCNT_W-1:0] clamped;
    logic              r_out_valid;
    t_out_item         r_out_data;
    t_dp_cmd           cmd;
    t_dp_stat          stat;
    t_out_item         result;
    logic              idle;
    logic              start;
    logic              out_free;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = idle;
    assign start       = i_in_valid && idle;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        priority if (i_cfg_data == '0) begin
            clamped = NCNT_W'(1);
        end else if (i_cfg_data > CFG_DATA_W'(MAX_VERTICES)) begin
            clamped = NCNT_W'(MAX_VERTICES);
        end else begin
            clamped = NCNT_W'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount    <= NCNT_W'(MAX_VERTICES);
            r_mode      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && i_cfg_index == CFG_VERTEX_COUNT) r_vcount <= clamped;
            if (i_cfg_valid && i_cfg_index == CFG_CENTER_MODE) r_mode <= i_cfg_data[1:0];
            if (cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.out_load) r_out_data <= result;
    end

    apc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_action   (i_in_data.action),
        .i_mode_bt  (r_mode == MODE_BETWEEN),
        .i_stat     (stat),
        .i_out_free (out_free),
        .o_cmd      (cmd),
        .o_idle     (idle)
    );

    apc_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_in_data),
        .i_vcount (r_vcount),
        .i_mode   (r_mode),
        .o_stat   (stat),
        .o_result (result)
    );

endmodule

// ===== design/apc_checker.sv =====
// ============================================================================
// apc_checker
// Port level checks of the all pairs path center finder, bound to the top.
// ============================================================================
`include "all_pairs_path_center_finder_assert.svh"

module apc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready
);

    `APC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    `APC_ASSERT_NEXT(a_busy_after_beat, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `APC_ASSERT_SAME(a_clear_after_reset, i_clk, i_rst_n, !$past(i_rst_n), !o_in_ready)
    `APC_ASSERT_SAME(a_no_out_after_reset, i_clk, i_rst_n, !$past(i_rst_n), !o_out_valid)

endmodule

bind all_pairs_path_center_finder apc_checker u_apc_checker (.*);

// ===== tb/all_pairs_path_center_finder_tb.sv =====
// ============================================================================
// all_pairs_path_center_finder_tb
// Self-checking testbench for the shortest path and graph center engine.
// A directed table covers reset state, range clamping, self-loops, ignored
// edges and every center mode, then random graph phases on small vertex
// counts follow. Each result beat is checked against an in-bench model of
// the distance and first-hop matrices, or against a value in the table.
// ============================================================================
module all_pairs_path_center_finder_tb
    import apc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000000;
    localparam int SETTLE_CYCLES  = 4200;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind kind;
        t_in_item  item;
        bit        typed;
        t_out_item res;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    logic [DIST_W-1:0] dist_mat [DEPTH];
    logic [HOP_W-1:0]  hop_mat  [DEPTH];
    int unsigned       n_vertices;
    logic [1:0]        mode_sel;

    t_out_item  pending_results [$];
    t_stim_row  directed_rows [$];
    int         errors = 0;
    int         items_sent = 0;
    int         results_seen = 0;
    int         idle_cycles = 0;
    int         out_stall = 0;
    bit         any_beat;

    all_pairs_path_center_finder dut (.*);

    always #1 i_clk = ~i_clk;

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch on result %0d, %s: got %0d expected %0d",
                 results_seen, field, got, want);
        errors++;
    endtask

    function automatic void graph_clear();
        for (int i = 0; i < DEPTH; i++) begin
            dist_mat[i] = DIST_INF;
            hop_mat[i]  = HOP_NONE;
        end
    endfunction

    function automatic logic [DIST_W-1:0] sat_sum(logic [DIST_W-1:0] x, logic [DIST_W-1:0] y);
        longint s;
        s = longint'(x) + longint'(y);
        return (s >= longint'(DIST_INF)) ? DIST_INF : DIST_W'(s);
    endfunction

    function automatic logic [VTX_W-1:0] find_center();
        int unsigned best;
        longint      best_val;
        longint      v;
        int          cnt [MAX_VERTICES];
        logic [DIST_W-1:0] c;
        logic [HOP_W-1:0]  p;
        best = 0;
        best_val = 0;
        for (int k = 0; k < n_vertices; k++)
            for (int i = 0; i < n_vertices; i++)
                for (int j = 0; j < n_vertices; j++) begin
                    c = sat_sum(dist_mat[i*MAX_VERTICES+k], dist_mat[k*MAX_VERTICES+j]);
                    if (c < dist_mat[i*MAX_VERTICES+j]) begin
                        dist_mat[i*MAX_VERTICES+j] = c;
                        hop_mat[i*MAX_VERTICES+j]  = hop_mat[i*MAX_VERTICES+k];
                    end
                end
        if (mode_sel == MODE_BETWEEN) begin
            for (int i = 0; i < MAX_VERTICES; i++) cnt[i] = 0;
            for (int i = 0; i + 1 < n_vertices; i++)
                for (int j = i + 1; j < n_vertices; j++) begin
                    p = hop_mat[i*MAX_VERTICES+j];
                    if (p == HOP_NONE || p == i || p == j) continue;
                    if (cnt[p] < BT_MAX) cnt[p]++;
                end
            best_val = cnt[0];
            for (int i = 1; i < n_vertices; i++)
                if (cnt[i] > best_val) begin
                    best_val = cnt[i];
                    best = i;
                end
            return VTX_W'(best);
        end
        for (int i = 0; i < n_vertices; i++) begin
            v = 0;
            for (int j = 0; j < n_vertices; j++) begin
                if (mode_sel == MODE_MAX) begin
                    if (dist_mat[i*MAX_VERTICES+j] > v) v = dist_mat[i*MAX_VERTICES+j];
                end else begin
                    v += dist_mat[i*MAX_VERTICES+j];
                end
            end
            if (i == 0 || v < best_val) begin
                best_val = v;
                best = i;
            end
        end
        return VTX_W'(best);
    endfunction

    function automatic bit predict_step(t_in_item it, output t_out_item res);
        int unsigned a, b;
        logic [HOP_W-1:0] v;
        a = it.vertex_a;
        b = it.vertex_b;
        res = '0;
        case (it.action)
            ACT_CLEAR: begin
                graph_clear();
                return 1'b0;
            end
            ACT_EDGE: begin
                if (a < n_vertices && b < n_vertices) begin
                    dist_mat[a*MAX_VERTICES+a] = '0;
                    hop_mat[a*MAX_VERTICES+a]  = HOP_W'(a);
                    dist_mat[b*MAX_VERTICES+b] = '0;
                    hop_mat[b*MAX_VERTICES+b]  = HOP_W'(b);
                    dist_mat[a*MAX_VERTICES+b] = DIST_W'(it.edge_weight);
                    dist_mat[b*MAX_VERTICES+a] = DIST_W'(it.edge_weight);
                    hop_mat[a*MAX_VERTICES+b]  = HOP_W'(b);
                    hop_mat[b*MAX_VERTICES+a]  = HOP_W'(a);
                end
                return 1'b0;
            end
            ACT_COMPUTE: begin
                res.chosen_vertex = find_center();
                return 1'b1;
            end
            default: begin
                res.result_kind = 1'b1;
                res.path_distance = DIST_INF;
                if (a < n_vertices && b < n_vertices) begin
                    v = hop_mat[a*MAX_VERTICES+b];
                    if (v != HOP_NONE) begin
                        res.chosen_vertex = v[VTX_W-1:0];
                        res.path_distance = dist_mat[a*MAX_VERTICES+v];
                        res.hop_known = 1'b1;
                    end
                end
                return 1'b1;
            end
        endcase
    endfunction

    task automatic send_item(t_in_item it, bit typed, t_out_item typed_res);
        int gap;
        t_out_item res;
        gap = $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        if (predict_step(it, res))
            pending_results.insert(pending_results.size(), typed ? typed_res : res);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_VERTEX_COUNT)
            n_vertices = (data == 0) ? 1 : (data > MAX_VERTICES) ? MAX_VERTICES : data;
        else if (idx == CFG_CENTER_MODE)
            mode_sel = data[1:0];
    endtask

    function automatic t_out_item miss_res();
        t_out_item r;
        r = '0;
        r.result_kind = 1'b1;
        r.path_distance = DIST_INF;
        return r;
    endfunction

    function automatic t_stim_row row(t_row_kind kind, logic [1:0] act, int a, int b,
                                      int w, bit typed = 1'b0, t_out_item res = '0);
        t_stim_row r;
        r.kind = kind;
        r.item.action = act;
        r.item.vertex_a = VTX_W'(a);
        r.item.vertex_b = VTX_W'(b);
        r.item.edge_weight = WEIGHT_W'(w);
        r.typed = typed;
        r.res = res;
        return r;
    endfunction

    function automatic t_out_item hop_res(int v, int d);
        t_out_item r;
        r = '0;
        r.result_kind = 1'b1;
        r.chosen_vertex = VTX_W'(v);
        r.path_distance = DIST_W'(d);
        r.hop_known = 1'b1;
        return r;
    endfunction

    function automatic int rand_vertex(int n);
        return ($urandom_range(0, 6) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
    endfunction

    function automatic int rand_weight();
        return ($urandom_range(0, 1) == 0) ? $urandom_range(0, 24'hFFFFFF)
                                           : $urandom_range(0, 4095);
    endfunction

    always @(posedge i_clk) begin
        int next_ready;
        t_out_item want;
        next_ready = i_out_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected beat", 1, 0);
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (o_out_data.result_kind !== want.result_kind)
                    report_mismatch("result_kind", o_out_data.result_kind, want.result_kind);
                if (o_out_data.chosen_vertex !== want.chosen_vertex)
                    report_mismatch("chosen_vertex", o_out_data.chosen_vertex,
                                    want.chosen_vertex);
                if (o_out_data.path_distance !== want.path_distance)
                    report_mismatch("path_distance", o_out_data.path_distance,
                                    want.path_distance);
                if (o_out_data.hop_known !== want.hop_known)
                    report_mismatch("hop_known", o_out_data.hop_known, want.hop_known);
            end
            results_seen++;
            out_stall = $urandom_range(0, 4);
            next_ready = (out_stall == 0);
        end else if (out_stall > 0) begin
            out_stall--;
            next_ready = 0;
        end else begin
            next_ready = 1;
        end
        i_out_ready <= next_ready[0];
    end

    always @(posedge i_clk) begin
        any_beat = (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                   || (i_cfg_valid && o_cfg_ready);
        idle_cycles = any_beat ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results pending", pending_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int n;
        int pick;
        t_in_item it;
        logic [63:0] raw;
        graph_clear();
        n_vertices = MAX_VERTICES;
        mode_sel = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed_rows.push_back(row(ROW_ITEM, ACT_QUERY, 0, 0, 0, 1, miss_res()));
        directed_rows.push_back(row(ROW_ITEM, ACT_QUERY, 63, 0, 0, 1, miss_res()));
        directed_rows.push_back(row(ROW_ITEM, ACT_COMPUTE, 0, 0, 0, 1, '0));
        directed_rows.push_back(row(ROW_CFG, CFG_VERTEX_COUNT, 0, 0, 0));
        directed_rows.push_back(row(ROW_ITEM, ACT_EDGE, 0, 0, 24'hFFFFFF));
        directed_rows.push_back(row(ROW_ITEM, ACT_EDGE, 1, 0, 5));
        directed_rows.push_back(row(ROW_ITEM, ACT_QUERY, 0, 0, 0, 1, hop_res(0, 24'hFFFFFF)));
        directed_rows.push_back(row(ROW_ITEM, ACT_QUERY, 0, 1, 0, 1, miss_res()));
        directed_rows.push_back(row(ROW_ITEM, ACT_COMPUTE, 0, 0, 0, 1, '0));
        directed_rows.push_back(row(ROW_CFG, CFG_VERTEX_COUNT, 0, 0, 4));
        directed_rows.push_back(row(ROW_CFG, CFG_CENTER_MODE, 0, 0, 1));
        directed_rows.push_back(row(ROW_ITEM, ACT_CLEAR, 0, 0, 0));
        directed_rows.push_back(row(ROW_ITEM, ACT_EDGE, 0, 1, 0));
        directed_rows.push_back(row(ROW_ITEM, ACT_EDGE, 1, 2, 24'hFFFFFF));
        directed_rows.push_back(row(ROW_ITEM, ACT_EDGE, 2, 3, 100));
        directed_rows.push_back(row(ROW_ITEM, ACT_EDGE, 0, 3, 24'h800));
        directed_rows.push_back(row(ROW_ITEM, ACT_COMPUTE, 0, 0, 0));
        directed_rows.push_back(row(ROW_ITEM, ACT_QUERY, 0, 2, 0));
        directed_rows.push_back(row(ROW_ITEM, ACT_QUERY, 3, 1, 0));
        directed_rows.push_back(row(ROW_CFG, CFG_CENTER_MODE, 0, 0, 3));
        directed_rows.push_back(row(ROW_ITEM, ACT_COMPUTE, 0, 0, 0));
        directed_rows.push_back(row(ROW_CFG, CFG_CENTER_MODE, 0, 0, 2));
        directed_rows.push_back(row(ROW_ITEM, ACT_COMPUTE, 0, 0, 0));
        directed_rows.push_back(row(ROW_CFG, CFG_VERTEX_COUNT, 0, 0, 127));
        directed_rows.push_back(row(ROW_CFG, CFG_VERTEX_COUNT, 0, 0, 6));
        directed_rows.push_back(row(ROW_ITEM, ACT_QUERY, 5, 0, 0));
        directed_rows.push_back(row(ROW_ITEM, ACT_QUERY, 3, 5, 0));

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG)
                write_reg(directed_rows[r].item.action,
                          CFG_DATA_W'(directed_rows[r].item.edge_weight));
            else
                send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].res);
        end

        for (int ph = 0; ph < 5; ph++) begin
            n = $urandom_range(2, 8);
            write_reg(CFG_VERTEX_COUNT, CFG_DATA_W'(n));
            write_reg(CFG_CENTER_MODE, CFG_DATA_W'($urandom_range(0, 3)));
            send_item(row(ROW_ITEM, ACT_CLEAR, 0, 0, 0).item, 1'b0, '0);
            for (int s = 0; s < 14; s++) begin
                pick = $urandom_range(0, 9);
                if (pick <= 5) begin
                    it = row(ROW_ITEM, ACT_EDGE, rand_vertex(n), rand_vertex(n),
                             rand_weight()).item;
                end else if (pick <= 7) begin
                    it = row(ROW_ITEM, ACT_QUERY, rand_vertex(n), rand_vertex(n), 0).item;
                end else if (pick == 8 || s == 13) begin
                    it = row(ROW_ITEM, ACT_COMPUTE, 0, 0, 0).item;
                end else begin
                    raw = {$urandom, $urandom};
                    it = raw[$bits(t_in_item)-1:0];
                end
                send_item(it, 1'b0, '0);
            end
            for (int q = 0; q < 3; q++)
                send_item(row(ROW_ITEM, ACT_QUERY, rand_vertex(n), rand_vertex(n), 0).item,
                          1'b0, '0);
        end

        settle();
        if (pending_results.size() != 0) begin
            report_mismatch("missing beats", 0, pending_results.size());
        end
        $display("Sent %0d input beats and checked %0d result beats over all four center",
                 items_sent, results_seen);
        $display("modes, vertex counts from 1 to 64 and random small graphs; %0d errors.",
                 errors);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+design
design/apc_pkg.sv
design/apc_ram.sv
design/apc_ctrl.sv
design/apc_dp.sv
design/all_pairs_path_center_finder.sv
design/apc_checker.sv
tb/all_pairs_path_center_finder_tb.sv
